@@ rtl/core/ntt_pkg.sv @@
// ntt_pkg: constants and mode codes for the 2x2 NTT butterfly.
// No dependencies.
package ntt_pkg;
    localparam int unsigned MODULUS_DEF = 8380417;
    localparam int unsigned COEF_W      = 23;
    localparam int unsigned MODE_W      = 2;

    localparam logic [MODE_W-1:0] MODE_FWD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INV = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PWM = 2'd2;
endpackage

@@ rtl/core/ntt_modmul.sv @@
// ntt_modmul: modular multiplier, product then Barrett reduction mod MODULUS.
// Registered product, quotient estimate, remainder and correction; one item per cycle. Uses ntt_pkg.
module ntt_modmul #(
    parameter int unsigned MODULUS = ntt_pkg::MODULUS_DEF
) (
    input  logic                        i_clk,
    input  logic [ntt_pkg::COEF_W-1:0]  i_x,
    input  logic [ntt_pkg::COEF_W-1:0]  i_y,
    output logic [ntt_pkg::COEF_W-1:0]  o_p
);
    import ntt_pkg::*;
    localparam int unsigned PW = 2 * COEF_W;
    // 2^(L-1) <= q < 2^L; operands are below q so the product is below 2^(2L)
    localparam int unsigned L  = $clog2(MODULUS + 1);
    localparam int unsigned HW = COEF_W + 3;
    // Barrett: mu = floor(2^(2L) / q), remainder estimate lands in 0..3q-1
    localparam logic [HW-1:0] MU = HW'((64'd1 << (2 * L)) / 64'(MODULUS));
    localparam logic [HW-1:0] QH = HW'(MODULUS);

    logic [PW-1:0]     r_prod;
    logic [HW-1:0]     w_xh;
    logic [2*HW-1:0]   w_qm;
    logic [HW-1:0]     r_qh;
    logic [HW-1:0]     r_xlo;
    logic [HW-1:0]     w_rem;
    logic [HW-1:0]     r_rem;
    logic [HW-1:0]     n_red;
    logic [COEF_W-1:0] r_p;

    // product
    always_ff @(posedge i_clk) begin
        r_prod <= PW'(i_x) * PW'(i_y);
    end

    // quotient estimate
    always_comb begin
        w_xh = HW'(r_prod >> (L - 1));
        w_qm = (2*HW)'(w_xh) * (2*HW)'(MU);
    end

    always_ff @(posedge i_clk) begin
        r_qh  <= HW'(w_qm >> (L + 1));
        r_xlo <= HW'(r_prod);
    end

    // remainder, exact in HW bits since it is below 3q
    assign w_rem = r_xlo - r_qh * QH;

    always_ff @(posedge i_clk) begin
        r_rem <= w_rem;
    end

    // final correction
    always_comb begin
        n_red = r_rem;
        if (n_red >= QH) n_red = n_red - QH;
        if (n_red >= QH) n_red = n_red - QH;
    end

    always_ff @(posedge i_clk) begin
        r_p <= COEF_W'(n_red);
    end

    assign o_p = r_p;
endmodule

@@ rtl/core/ntt_two_by_two_butterfly.sv @@
// ntt_two_by_two_butterfly: top level, two layers of radix-2 butterflies mod q.
// Depends on ntt_pkg and ntt_modmul.
//
//  channel | ports                                  | direction | handshake
//  --------+----------------------------------------+-----------+----------------------
//  item in | i_coef_a..d, i_twiddle_one..four        | in        | start & !busy
//  result  | o_out_a..d                             | out       | o_done, one cycle
//  config  | i_cfg_we, i_cfg_mode                   | in        | i_cfg_we
//
// An item taken at one edge reaches the outputs with o_done after passing
// through every stage listed below. One item can enter every cycle.
// Stages: input reduce (1), layer-1 pre add/sub (1), modmul (4), combine (1),
// halve and lane swap (1), layer-2 pre add/sub (1), modmul (4), combine (1),
// halve (1). busy is tied low: the receiver cannot stall, so the pipe never stops.
// Reset (synchronous, active low) clears valid bits and sets mode to forward.
module ntt_two_by_two_butterfly #(
    parameter int unsigned MODULUS = ntt_pkg::MODULUS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cfg_we,
    input  logic [ntt_pkg::MODE_W-1:0]    i_cfg_mode,
    input  logic [ntt_pkg::COEF_W-1:0]    i_coef_a,
    input  logic [ntt_pkg::COEF_W-1:0]    i_coef_b,
    input  logic [ntt_pkg::COEF_W-1:0]    i_coef_c,
    input  logic [ntt_pkg::COEF_W-1:0]    i_coef_d,
    input  logic [ntt_pkg::COEF_W-1:0]    i_twiddle_one,
    input  logic [ntt_pkg::COEF_W-1:0]    i_twiddle_two,
    input  logic [ntt_pkg::COEF_W-1:0]    i_twiddle_three,
    input  logic [ntt_pkg::COEF_W-1:0]    i_twiddle_four,
    output logic                          o_done,
    output logic [ntt_pkg::COEF_W-1:0]    o_out_a,
    output logic [ntt_pkg::COEF_W-1:0]    o_out_b,
    output logic [ntt_pkg::COEF_W-1:0]    o_out_c,
    output logic [ntt_pkg::COEF_W-1:0]    o_out_d
);
    import ntt_pkg::*;
    localparam int unsigned W  = COEF_W;
    localparam logic [W:0]  QX = (W+1)'(MODULUS);
    localparam logic [W:0]  HALF_UP = (W+1)'((MODULUS + 1) / 2);
    localparam int unsigned LAT = 15;

    typedef logic [W-1:0] t_coef;
    typedef logic [3:0][W-1:0] t_quad;
    typedef logic [1:0][W-1:0] t_pair;

    // ---- modular helpers on narrow values ----
    function automatic t_coef f_red(input logic [W:0] v);
        logic [W:0] t;
        t = v;
        if (t >= QX) t = t - QX;
        if (t >= QX) t = t - QX;
        return t_coef'(t);
    endfunction

    function automatic t_coef f_add(input t_coef x, input t_coef y);
        return f_red((W+1)'(x) + (W+1)'(y));
    endfunction

    function automatic t_coef f_sub(input t_coef x, input t_coef y);
        logic [W+1:0] s;
        logic [W+1:0] q2;
        q2 = (W+2)'(MODULUS);
        s = (W+2)'(x) + q2 - (W+2)'(y);
        if (s >= q2) s = s - q2;
        if (s >= q2) s = s - q2;
        return t_coef'(s);
    endfunction

    function automatic t_coef f_half(input t_coef v);
        logic [W:0] h;
        h = (W+1)'(v >> 1);
        if (v[0]) h = h + HALF_UP;
        return f_red(h);
    endfunction

    // mode register
    logic [MODE_W-1:0] r_mode;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_FWD;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_mode;
        end
    end
    logic w_pwm, w_inv;
    assign w_pwm = r_mode[1];
    assign w_inv = (r_mode == MODE_INV);

    assign busy = 1'b0;
    logic w_acc;
    assign w_acc = start & ~busy;

    // valid shift line; mode flags ride along with each item
    // bit k belongs to the item held in the stage-k registers
    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] r_pw;
    logic [LAT-1:0] r_iv;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], w_acc};
        end
        r_pw <= {r_pw[LAT-2:0], w_pwm};
        r_iv <= {r_iv[LAT-2:0], w_inv};
    end

    // ---- stage 0: input reduce ----
    t_quad r0_c, r0_t;
    always_ff @(posedge i_clk) begin
        r0_c <= {f_red({1'b0, i_coef_d}), f_red({1'b0, i_coef_c}),
                 f_red({1'b0, i_coef_b}), f_red({1'b0, i_coef_a})};
        r0_t <= {f_red({1'b0, i_twiddle_four}), f_red({1'b0, i_twiddle_three}),
                 f_red({1'b0, i_twiddle_two}), f_red({1'b0, i_twiddle_one})};
    end

    // ---- layer 1 ----
    // stage 1: in inverse mode form sums/diffs first; forward/pwm pass through
    t_quad r1_x;   // operands for the adder side
    t_quad r1_m;   // multiplicand into multipliers
    t_quad r1_w;   // multipliers
    always_ff @(posedge i_clk) begin
        if (r_iv[0]) begin
            r1_x[0] <= f_add(r0_c[0], r0_c[1]);
            r1_m[1] <= f_sub(r0_c[0], r0_c[1]);
            r1_x[2] <= f_add(r0_c[2], r0_c[3]);
            r1_m[3] <= f_sub(r0_c[2], r0_c[3]);
        end else begin
            r1_x[0] <= r0_c[0];
            r1_m[1] <= r0_c[1];
            r1_x[2] <= r0_c[2];
            r1_m[3] <= r0_c[3];
        end
        r1_x[1] <= '0;
        r1_x[3] <= '0;
        r1_m[0] <= r0_c[0];
        r1_m[2] <= r0_c[2];
        r1_w[0] <= r0_t[0];
        r1_w[1] <= r_pw[0] ? r0_t[1] : r0_t[0];
        r1_w[2] <= r0_t[2];
        r1_w[3] <= r_pw[0] ? r0_t[3] : r0_t[1];
    end
    t_quad r1_tw;  // second-layer twiddles carried along
    t_quad r2_tw, r3_tw, r4_tw, r5_tw, r6_tw;
    t_quad r2_x, r3_x, r4_x, r5_x;
    always_ff @(posedge i_clk) begin
        r1_tw <= r0_t;
        r2_tw <= r1_tw; r3_tw <= r2_tw; r4_tw <= r3_tw;
        r5_tw <= r4_tw; r6_tw <= r5_tw;
        r2_x <= r1_x; r3_x <= r2_x; r4_x <= r3_x; r5_x <= r4_x;
    end

    // stages 2-5: four multipliers (pointwise uses all four)
    t_quad w_p1;
    for (genvar g = 0; g < 4; g++) begin : g_mul1
        ntt_modmul #(.MODULUS(MODULUS)) u_mul (
            .i_clk (i_clk),
            .i_x   (r1_m[g]),
            .i_y   (r1_w[g]),
            .o_p   (w_p1[g])
        );
    end

    // stage 6: butterfly combine
    t_quad r6_y;
    always_ff @(posedge i_clk) begin
        if (r_pw[5]) begin
            r6_y <= w_p1;
        end else if (r_iv[5]) begin
            r6_y <= {w_p1[3], r5_x[2], w_p1[1], r5_x[0]};
        end else begin
            r6_y <= {f_sub(r5_x[2], w_p1[3]), f_add(r5_x[2], w_p1[3]),
                     f_sub(r5_x[0], w_p1[1]), f_add(r5_x[0], w_p1[1])};
        end
    end
    // stage 7: halving (inverse) and lane swap -> a1 c1 | b1 d1
    t_quad r7_y, r7_tw;
    always_ff @(posedge i_clk) begin
        r7_tw <= r6_tw;
        if (r_pw[6]) begin
            r7_y <= r6_y;
        end else if (r_iv[6]) begin
            r7_y <= {f_half(r6_y[3]), f_half(r6_y[1]),
                     f_half(r6_y[2]), f_half(r6_y[0])};
        end else begin
            r7_y <= {r6_y[3], r6_y[1], r6_y[2], r6_y[0]};
        end
    end

    // ---- layer 2 ---- (pairs (0,1) with tw3, (2,3) with tw4)
    // stage 8; multiplier pair index 0 is lane 1, index 1 is lane 3
    t_quad r8_x;
    t_pair r8_m, r8_w;
    always_ff @(posedge i_clk) begin
        if (r_iv[7] && !r_pw[7]) begin
            r8_x[0] <= f_add(r7_y[0], r7_y[1]);
            r8_m[0] <= f_sub(r7_y[0], r7_y[1]);
            r8_x[2] <= f_add(r7_y[2], r7_y[3]);
            r8_m[1] <= f_sub(r7_y[2], r7_y[3]);
        end else begin
            r8_x[0] <= r7_y[0];
            r8_m[0] <= r7_y[1];
            r8_x[2] <= r7_y[2];
            r8_m[1] <= r7_y[3];
        end
        // pointwise products ride through all four lanes of r8_x
        r8_x[1] <= r7_y[1];
        r8_x[3] <= r7_y[3];
        r8_w[0] <= r7_tw[2];
        r8_w[1] <= r7_tw[3];
    end
    t_quad r9_x, r10_x, r11_x, r12_x;
    always_ff @(posedge i_clk) begin
        r9_x <= r8_x; r10_x <= r9_x; r11_x <= r10_x; r12_x <= r11_x;
    end
    // stages 9-12: two multipliers
    t_pair w_p2;
    for (genvar g = 0; g < 2; g++) begin : g_mul2
        ntt_modmul #(.MODULUS(MODULUS)) u_mul (
            .i_clk (i_clk),
            .i_x   (r8_m[g]),
            .i_y   (r8_w[g]),
            .o_p   (w_p2[g])
        );
    end

    // stage 13: combine
    t_quad r13_y;
    always_ff @(posedge i_clk) begin
        if (r_pw[12]) begin
            r13_y <= r12_x;
        end else if (r_iv[12]) begin
            r13_y <= {w_p2[1], r12_x[2], w_p2[0], r12_x[0]};
        end else begin
            r13_y <= {f_sub(r12_x[2], w_p2[1]), f_add(r12_x[2], w_p2[1]),
                      f_sub(r12_x[0], w_p2[0]), f_add(r12_x[0], w_p2[0])};
        end
    end
    // stage 14: halving, also the output register
    t_quad r14_y;
    always_ff @(posedge i_clk) begin
        if (r_iv[13] && !r_pw[13]) begin
            r14_y <= {f_half(r13_y[3]), f_half(r13_y[2]),
                      f_half(r13_y[1]), f_half(r13_y[0])};
        end else begin
            r14_y <= r13_y;
        end
    end

    assign o_done  = r_vld[LAT-1];
    assign o_out_a = r14_y[0];
    assign o_out_b = r14_y[1];
    assign o_out_c = r14_y[2];
    assign o_out_d = r14_y[3];

`ifndef SYNTH
    a_done_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> ##(LAT) o_done) else $error("result missing");
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_acc, LAT)) else $error("spurious result");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((o_out_a < MODULUS) && (o_out_b < MODULUS)
                 && (o_out_c < MODULUS) && (o_out_d < MODULUS)))
        else $error("result out of range");
`endif
endmodule

@@ sim/tb_top.sv @@
// tb_top: self-checking bench for ntt_two_by_two_butterfly (forward, inverse, pointwise).
// Depends on ntt_pkg and the block RTL; predicts each quad in place and compares in order.
`timescale 1ns / 100ps

module tb_top;
    import ntt_pkg::*;

    localparam longint unsigned Q       = MODULUS_DEF;
    localparam longint unsigned HALF_UP = (Q + 1) / 2;
    localparam int LATENCY  = 15;
    localparam int WDOG_MAX = 2000;
    localparam int N_RAND   = 610;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;  // undecoded code, acts as pointwise

    typedef logic [COEF_W-1:0] coef_t;
    typedef struct packed {
        coef_t a, b, c, d, w1, w2, w3, w4;
    } quad_in_t;
    typedef struct packed {
        coef_t a, b, c, d;
    } quad_out_t;
    // directed row: item, whether the expected quad is typed in, and that quad
    typedef struct {
        quad_in_t  item;
        bit        typed;
        quad_out_t want;
    } row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_we = 1'b0;
    logic [MODE_W-1:0] i_cfg_mode = MODE_FWD;
    coef_t       i_coef_a = '0, i_coef_b = '0, i_coef_c = '0, i_coef_d = '0;
    coef_t       i_twiddle_one = '0, i_twiddle_two = '0;
    coef_t       i_twiddle_three = '0, i_twiddle_four = '0;
    logic        o_done;
    coef_t       o_out_a, o_out_b, o_out_c, o_out_d;

    ntt_two_by_two_butterfly uut (
        .i_clk, .i_rst_n, .start, .busy, .i_cfg_we, .i_cfg_mode,
        .i_coef_a, .i_coef_b, .i_coef_c, .i_coef_d,
        .i_twiddle_one, .i_twiddle_two, .i_twiddle_three, .i_twiddle_four,
        .o_done, .o_out_a, .o_out_b, .o_out_c, .o_out_d
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    logic [MODE_W-1:0] cur_mode = MODE_FWD;  // shadow of the mode register
    quad_out_t pending_quads[$];
    int errors = 0;
    int idle_cycles = 0;
    int accepted_items = 0;

    // ---------------- predictor ----------------
    function automatic longint unsigned qadd(longint unsigned x, longint unsigned y);
        return (x + y) % Q;
    endfunction
    function automatic longint unsigned qsub(longint unsigned x, longint unsigned y);
        return (x + Q - y) % Q;
    endfunction
    function automatic longint unsigned qmul(longint unsigned x, longint unsigned y);
        return (x * y) % Q;
    endfunction
    // multiply by 2^-1 mod q
    function automatic longint unsigned qhalf(longint unsigned v);
        longint unsigned h;
        h = v >> 1;
        if (v[0]) h += HALF_UP;
        return h % Q;
    endfunction

    function automatic void butterfly(input bit inv, input longint unsigned w,
                                      input longint unsigned x, input longint unsigned y,
                                      output longint unsigned hi,
                                      output longint unsigned lo);
        longint unsigned t;
        if (inv) begin
            hi = qhalf(qadd(x, y));
            lo = qhalf(qmul(qsub(x, y), w));
        end else begin
            t  = qmul(w, y);
            hi = qadd(x, t);
            lo = qsub(x, t);
        end
    endfunction

    function automatic quad_out_t transform_quad(quad_in_t it, logic [MODE_W-1:0] md);
        longint unsigned v[8];
        longint unsigned r[4];
        longint unsigned a1, b1, c1, d1;
        quad_out_t o;
        v = '{it.a, it.b, it.c, it.d, it.w1, it.w2, it.w3, it.w4};
        foreach (v[i]) v[i] = v[i] % Q;  // out-of-range inputs fold back mod q
        if (md[1]) begin
            for (int i = 0; i < 4; i++) r[i] = qmul(v[i], v[4 + i]);
        end else begin
            butterfly(md == MODE_INV, v[4], v[0], v[1], a1, b1);
            butterfly(md == MODE_INV, v[5], v[2], v[3], c1, d1);
            butterfly(md == MODE_INV, v[6], a1, c1, r[0], r[1]);
            butterfly(md == MODE_INV, v[7], b1, d1, r[2], r[3]);
        end
        o.a = r[0][COEF_W-1:0];
        o.b = r[1][COEF_W-1:0];
        o.c = r[2][COEF_W-1:0];
        o.d = r[3][COEF_W-1:0];
        return o;
    endfunction

    // ---------------- result checker ----------------
    // Results cannot be held off: every o_done cycle is a result.
    always @(posedge i_clk) begin
        quad_out_t got, want;
        if (i_rst_n && o_done) begin
            got = '{o_out_a, o_out_b, o_out_c, o_out_d};
            if (pending_quads.size() == 0) begin
                $display("%0t: result with none pending, got %h", $time, got);
                errors++;
            end else begin
                want = pending_quads.pop_front();
                if (got.a !== want.a)
                    $display("%0t: out_a exp %0d got %0d", $time, want.a, got.a);
                if (got.b !== want.b)
                    $display("%0t: out_b exp %0d got %0d", $time, want.b, got.b);
                if (got.c !== want.c)
                    $display("%0t: out_c exp %0d got %0d", $time, want.c, got.c);
                if (got.d !== want.d)
                    $display("%0t: out_d exp %0d got %0d", $time, want.d, got.d);
                if (got !== want) errors++;
            end
        end
    end

    // watchdog: counts cycles with nothing accepted on either side
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    function automatic coef_t rand_coef();
        case ($urandom_range(0, 19))
            0:       return coef_t'(Q - 1);
            1:       return '0;
            2:       return coef_t'($urandom_range(0, 3));
            3:       return coef_t'($urandom_range(Q, (1 << COEF_W) - 1));  // out of range
            default: return coef_t'($urandom_range(0, Q - 1));
        endcase
    endfunction

    function automatic quad_in_t rand_quad();
        quad_in_t it;
        it = '{rand_coef(), rand_coef(), rand_coef(), rand_coef(),
               rand_coef(), rand_coef(), rand_coef(), rand_coef()};
        return it;
    endfunction

    // sender gap: mostly none, some short, a few long
    task automatic sender_gap();
        int n;
        case ($urandom_range(0, 9))
            0, 1, 2: n = $urandom_range(1, 3);
            3:       n = $urandom_range(10, 40);
            default: n = 0;
        endcase
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    // drive one item at the falling edge; accepted at the next rising edge.
    // start stays high so the next item can follow back to back.
    task automatic send_quad(input quad_in_t it, input bit typed, input quad_out_t want);
        start <= 1'b1;
        {i_coef_a, i_coef_b, i_coef_c, i_coef_d,
         i_twiddle_one, i_twiddle_two, i_twiddle_three, i_twiddle_four} <= it;
        do @(posedge i_clk); while (busy);
        pending_quads.push_back(typed ? want : transform_quad(it, cur_mode));
        accepted_items++;
        @(negedge i_clk);
    endtask

    // stop sending, wait for all results, let the pipe drain, then write the mode
    task automatic write_mode(input logic [MODE_W-1:0] md);
        start <= 1'b0;
        wait (pending_quads.size() == 0);
        repeat (LATENCY + 2) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_mode <= md;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cur_mode = md;
    endtask

    localparam coef_t QM1 = coef_t'(Q - 1);
    localparam coef_t ALL1 = '1;
    row_t directed[$];

    initial begin
        logic [MODE_W-1:0] modes[5];
        // typed rows: zeros (every mode), q-1, identity twiddles; all-ones folds mod q
        directed = '{
            '{'{0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0}},
            '{'{QM1, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{QM1, QM1, QM1, QM1}},
            '{'{1, 0, 0, 0, 1, 1, 1, 1}, 1'b1, '{1, 1, 1, 1}},
            '{'{QM1, QM1, QM1, QM1, QM1, QM1, QM1, QM1}, 1'b0, '{0, 0, 0, 0}},
            '{'{ALL1, ALL1, ALL1, ALL1, ALL1, ALL1, ALL1, ALL1}, 1'b0, '{0, 0, 0, 0}},
            '{'{coef_t'(Q), 5, 7, 9, 2, 3, 4, 6}, 1'b0, '{0, 0, 0, 0}},
            '{'{1, 2, 3, 4, 0, 0, 0, 0}, 1'b0, '{0, 0, 0, 0}},
            '{'{23'h555555, 23'h2AAAAA, 23'h555555, 23'h2AAAAA,
                23'h2AAAAA, 23'h555555, 23'h2AAAAA, 23'h555555}, 1'b0, '{0, 0, 0, 0}}
        };

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part in forward (reset value), then inverse, pointwise, spare, forward
        modes = '{MODE_FWD, MODE_INV, MODE_PWM, MODE_SPARE, MODE_FWD};
        foreach (modes[m]) begin
            if (m > 0) write_mode(modes[m]);
            foreach (directed[r]) begin
                // only the zero row's typed value holds in every mode
                send_quad(directed[r].item, directed[r].typed && (r == 0 || m == 0),
                          directed[r].want);
            end
        end

        // random part: phases of streams per mode, mostly back-to-back
        for (int k = 0; k < N_RAND; k++) begin
            if (k % 80 == 0) write_mode(modes[$urandom_range(0, 3)]);
            if (k == N_RAND / 2) begin
                // drain once mid-run
                start <= 1'b0;
                wait (pending_quads.size() == 0);
                @(negedge i_clk);
            end
            if (k % 30 < 12) sender_gap();
            send_quad(rand_quad(), 1'b0, '{0, 0, 0, 0});
        end

        start <= 1'b0;
        wait (pending_quads.size() == 0);
        repeat (LATENCY + 5) @(negedge i_clk);
        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule

@@ ntt_two_by_two_butterfly.f @@
rtl/core/ntt_pkg.sv
rtl/core/ntt_modmul.sv
rtl/core/ntt_two_by_two_butterfly.sv
sim/tb_top.sv
